>>> hdl/name_character_sanitizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the name character sanitizer checker
// Concurrent property wrappers, clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef NAME_CHARACTER_SANITIZER_ASSERT_SVH
`define NAME_CHARACTER_SANITIZER_ASSERT_SVH

// Same-cycle implication.
`define NCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/nmsan_pkg.sv
// ----------------------------------------------------------------------------
// nmsan_pkg
// Types, character codes and helpers for the name character sanitizer.
// ----------------------------------------------------------------------------
package nmsan_pkg;

  localparam logic [7:0] MAX_NAME_LEN = 8'd32;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_H      = 8'h68;

  // Fallback name is emitted only when the buffer holds more than this.
  localparam logic [7:0] PATCH_MIN_CAP = 8'd5;

  localparam logic [7:0] CAP_RESET = 8'd33;

  // What one accepted character turns into on the output side.
  typedef enum logic [1:0] {
    BK_CHAR,        // one kept character
    BK_SPACE_CHAR,  // a collapsed space, then the kept character
    BK_TERM,        // terminator only
    BK_PATCH_TERM   // fallback name, then terminator
  } burst_kind_t;

  localparam logic [2:0] POS_SPACE_CHAR_LAST = 3'd1;
  localparam logic [2:0] POS_PATCH_TERM_LAST = 3'd5;

  function automatic logic keep_byte(input logic [7:0] c);
    keep_byte = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39) || c == CH_HYPHEN || c == CH_UNDER;
  endfunction

  function automatic logic [7:0] patch_char(input logic [2:0] pos);
    unique case (pos)
      3'd0:    patch_char = CH_P;
      3'd1:    patch_char = CH_A;
      3'd2:    patch_char = CH_T;
      3'd3:    patch_char = CH_C;
      3'd4:    patch_char = CH_H;
      default: patch_char = CH_NUL;
    endcase
  endfunction

endpackage

>>> hdl/name_character_sanitizer.sv
// ----------------------------------------------------------------------------
// name_character_sanitizer
// Cleans a zero-terminated name streamed one byte per transaction.
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                        | accepted when
//  ----------+-----+--------------------------------+-------------------------
//  in_*      | in  | tdata[7:0] = in_char           | in_tvalid && in_tready
//  out_*     | out | tdata[7:0] = out_char,         | out_tvalid && out_tready
//            |     | tlast = run_last, tuser = end  |
//  cfg_*     | in  | cfg_data[7:0] = out_capacity   | cfg_valid && cfg_ready
//
//  At most one input transaction per cycle; in_tready is low while a byte
//  with a result waits for the burst register. A collapsed space goes out
//  before its character; the terminator alone, or after the fallback name.
//  The burst register sets the rate: one result per cycle with out_tready high.
//  rst clears the name state, both stage valids and sets out_capacity to 33.
//  A stalled output holds the burst register; the input register still
//  takes one more byte, and bytes with no result retire without waiting.
// ----------------------------------------------------------------------------
module name_character_sanitizer (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // run_last
  output logic       out_tuser,  // [0] name_end
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data    // [7:0] out_capacity
);
  import nmsan_pkg::*;

  // configuration
  logic [7:0] out_capacity;

  // input register
  logic       in_full;
  logic [7:0] in_char;

  // name state
  logic [7:0] emitted_count, emitted_count_next;
  logic       space_pending, space_pending_next;
  logic       output_stopped, output_stopped_next;

  // burst register
  logic        bst_valid;
  burst_kind_t bst_kind;
  logic [7:0]  bst_char;
  logic [2:0]  bst_pos;

  // decode
  logic        dec_emit;
  burst_kind_t dec_kind;
  logic [7:0]  lim;
  logic        bst_last;
  logic        bst_done;
  logic        consume;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      out_capacity <= cfg_data;
    end
  end

  // Limit is min(capacity - 1, MAX_NAME_LEN); zero capacity means zero.
  always_comb begin
    lim = (out_capacity == 8'd0) ? 8'd0 : out_capacity - 8'd1;
    if (lim > MAX_NAME_LEN) begin
      lim = MAX_NAME_LEN;
    end
  end

  // Work out the result burst and the state update for the held byte.
  always_comb begin
    dec_emit            = 1'b0;
    dec_kind            = BK_CHAR;
    emitted_count_next  = emitted_count;
    space_pending_next  = space_pending;
    output_stopped_next = output_stopped;
    priority if (in_char == CH_NUL) begin
      dec_emit = 1'b1;
      dec_kind = (emitted_count == 8'd0 && out_capacity > PATCH_MIN_CAP) ?
                 BK_PATCH_TERM : BK_TERM;
      emitted_count_next  = 8'd0;
      space_pending_next  = 1'b0;
      output_stopped_next = 1'b0;
    end else if (output_stopped) begin
      // drop everything until the terminator
    end else if (in_char == CH_SPACE) begin
      // leading spaces never become pending
      if (emitted_count != 8'd0) begin
        space_pending_next = 1'b1;
      end
    end else if (!keep_byte(in_char)) begin
      // drop disallowed bytes
    end else if (space_pending) begin
      // the space needs room for itself and the character after it
      if ({1'b0, emitted_count} + 9'd2 > {1'b0, lim}) begin
        output_stopped_next = 1'b1;
      end else begin
        dec_emit           = 1'b1;
        dec_kind           = BK_SPACE_CHAR;
        emitted_count_next = emitted_count + 8'd2;
        space_pending_next = 1'b0;
      end
    end else if ({1'b0, emitted_count} + 9'd1 > {1'b0, lim}) begin
      output_stopped_next = 1'b1;
    end else begin
      dec_emit           = 1'b1;
      dec_kind           = BK_CHAR;
      emitted_count_next = emitted_count + 8'd1;
    end
  end

  always_comb begin
    unique case (bst_kind)
      BK_SPACE_CHAR: bst_last = (bst_pos == POS_SPACE_CHAR_LAST);
      BK_PATCH_TERM: bst_last = (bst_pos == POS_PATCH_TERM_LAST);
      default:       bst_last = 1'b1;
    endcase
  end

  assign bst_done = bst_valid && out_tready && bst_last;
  // A byte with no result retires at once; otherwise wait for a free burst.
  assign consume   = in_full && (!dec_emit || !bst_valid || bst_done);
  assign in_tready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_tready) begin
      in_full <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count  <= 8'd0;
      space_pending  <= 1'b0;
      output_stopped <= 1'b0;
    end else if (consume) begin
      emitted_count  <= emitted_count_next;
      space_pending  <= space_pending_next;
      output_stopped <= output_stopped_next;
    end
  end

  // Load a new burst, or advance through the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      bst_valid <= 1'b0;
    end else if (consume && dec_emit) begin
      bst_valid <= 1'b1;
    end else if (bst_done) begin
      bst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && dec_emit) begin
      bst_kind <= dec_kind;
      bst_char <= in_char;
      bst_pos  <= 3'd0;
    end else if (bst_valid && out_tready && !bst_last) begin
      bst_pos <= bst_pos + 3'd1;
    end
  end

  assign out_tvalid = bst_valid;
  assign out_tlast  = bst_last;

  always_comb begin
    unique case (bst_kind)
      BK_CHAR: begin
        out_tdata = bst_char;
        out_tuser = 1'b0;
      end
      BK_SPACE_CHAR: begin
        out_tdata = (bst_pos == 3'd0) ? CH_SPACE : bst_char;
        out_tuser = 1'b0;
      end
      BK_TERM: begin
        out_tdata = CH_NUL;
        out_tuser = 1'b1;
      end
      BK_PATCH_TERM: begin
        out_tdata = patch_char(bst_pos);
        out_tuser = (bst_pos == POS_PATCH_TERM_LAST);
      end
      default: begin
        out_tdata = CH_NUL;
        out_tuser = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/nmsan_checker.sv
// ----------------------------------------------------------------------------
// nmsan_checker
// Port-level checks for the name character sanitizer, bound to the top.
// ----------------------------------------------------------------------------
`include "name_character_sanitizer_assert.svh"

module nmsan_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);
  import nmsan_pkg::*;

  `NCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result changed while stalled")
  `NCS_ASSERT_NOW(a_end_is_last, out_tvalid && out_tuser, out_tlast && out_tdata == CH_NUL, "terminator not last or not zero")
  `NCS_ASSERT_NOW(a_zero_is_end, out_tvalid && out_tdata == CH_NUL, out_tuser, "zero byte outside terminator")
  `NCS_ASSERT_NOW(a_backpressure, !in_tready, out_tvalid, "input held with nothing to deliver")

endmodule

bind name_character_sanitizer nmsan_checker u_nmsan_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
